// File: rtl/assert_macros.svh
// Assertion macros shared by the range finder RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// label: antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// label: expression holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`endif

// File: rtl/trhf_pkg.sv
// Types and constants for the tangent range and height finder.
// No dependencies.
`timescale 1ns / 1ps
package trhf_pkg;
    localparam int unsigned MAX_TERMS_DEF = 16;
    localparam logic [31:0] ANGLE_LIMIT   = 32'd1503238553;
    localparam logic [22:0] IH_RESET      = 23'd98304;
    localparam logic [4:0]  TC_RESET      = 5'd7;
    localparam logic [1:0]  ERR_OK        = 2'd0;
    localparam logic [1:0]  ERR_ALPHA     = 2'd1;
    localparam logic [1:0]  ERR_BETA      = 2'd2;
    localparam logic [0:0]  REG_IH        = 1'b0;
    localparam logic [0:0]  REG_TC        = 1'b1;

    // operand selection for the shared divider
    typedef enum logic [1:0] {
        t_DIV_Q = 2'd0,  // (2i-1) << 62 / x
        t_DIV_V = 2'd1,  // 1 << 64 / d
        t_DIV_H = 2'd2   // dist << 32 / d1
    } t_div_op;

    typedef enum logic [3:0] {
        t_IDLE, t_CHECK, t_QSTART, t_QWAIT, t_VSTART, t_VWAIT,
        t_MUL, t_MUL2, t_BSTART, t_HSTART, t_HWAIT, t_FIN, t_OUT
    } t_state;

    typedef struct packed {
        logic     load;      // capture input word
        logic     init_a;    // start alpha recursion
        logic     init_b;    // start beta recursion
        logic     div_go;
        t_div_op  div_op;
        logic     take_q;    // form d from quotient
        logic     take_v;    // v from quotient, step i down
        logic     do_mul;    // upper half of product, form distance
        logic     mul_lo;    // lower half of product
        logic     take_h;
        logic     set_ea;
        logic     set_eb;
        logic     out_set;
        logic     out_clr;
    } t_cmd;

    typedef struct packed {
        logic alpha_ok;
        logic beta_ok;
        logic want;
        logic last_term; // i == 1
        logic div_done;
        logic out_busy;
    } t_sts;
endpackage

// File: rtl/tangent_range_height_finder.sv
// Top level of the tangent range and height finder: APB registers, sequencer, datapath.
// Depends on trhf_pkg, trhf_ctrl, trhf_datapath.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall | angle_alpha, angle_beta, want_height
//  out     | output    | o_out_valid/i_out_stall | distance, object_height, error_code, saturated
//  apb     | input     | psel/penable/pready  | instrument_height @0, term_count @4
//
// One word at a time. Each term but the last costs two serial divisions, the last
// one only the first. Then comes a product in two halves and, for height, one more
// division, plus control states. Reset is synchronous; registers return to 1.5 and
// 7 terms. The next word is taken once the result sits in the output register.
`timescale 1ns / 1ps
module tangent_range_height_finder #(
    parameter int unsigned MAX_TERMS = trhf_pkg::MAX_TERMS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_angle_alpha,
    input  logic [31:0] i_angle_beta,
    input  logic        i_want_height,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_distance,
    output logic [31:0] o_object_height,
    output logic [1:0]  o_error_code,
    output logic        o_saturated,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import trhf_pkg::*;
    logic [22:0] r_ih;
    logic [4:0]  r_tc;
    t_cmd w_cmd;
    t_sts w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ih <= IH_RESET; r_tc <= TC_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_IH:  r_ih <= pwdata[22:0];
                REG_TC:  r_tc <= pwdata[4:0];
                default: r_ih <= r_ih;
            endcase
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TC) ? {27'd0, r_tc} : {9'd0, r_ih};

    trhf_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    trhf_datapath #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_angle_alpha(i_angle_alpha), .i_angle_beta(i_angle_beta),
        .i_want_height(i_want_height), .i_ih(r_ih), .i_tc(r_tc),
        .i_out_stall(i_out_stall), .o_out_valid(o_out_valid),
        .o_distance(o_distance), .o_object_height(o_object_height),
        .o_error_code(o_error_code), .o_saturated(o_saturated)
    );
endmodule

// File: rtl/trhf_div.sv
// Restoring divider: floor((num << sh) / den), saturating to all ones.
// One quotient bit per cycle. No dependencies.
`timescale 1ns / 1ps
module trhf_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [63:0] i_num,
    input  logic [6:0]  i_sh,
    input  logic [63:0] i_den,
    output logic        o_done,
    output logic [63:0] o_q
);
    logic [63:0] r_q, n_q, r_r, n_r, r_num, r_den;
    logic [7:0]  r_p, n_p;
    logic        r_busy, n_busy, r_sat, n_sat, r_done, n_done;
    logic [6:0]  r_sh;
    logic        w_bit, w_carry;
    logic [63:0] w_rs;
    logic [7:0]  w_pos;

    always_comb begin
        w_pos = r_p - 8'd1;
        w_bit = 1'b0;
        if (w_pos >= {1'b0, r_sh} && (w_pos - {1'b0, r_sh}) < 8'd64)
            w_bit = r_num[6'(w_pos - {1'b0, r_sh})];
        w_carry = r_r[63];
        w_rs = {r_r[62:0], w_bit};
        n_q = r_q; n_r = r_r; n_p = r_p; n_busy = r_busy; n_sat = r_sat; n_done = 1'b0;
        if (i_go) begin
            n_q = '0; n_r = '0; n_p = 8'd64 + {1'b0, i_sh};
            n_sat = (i_den == '0); n_busy = (i_den != '0); n_done = (i_den == '0);
        end else if (r_busy) begin
            n_r = w_rs;
            if (r_q[63]) n_sat = 1'b1;
            n_q = {r_q[62:0], 1'b0};
            if (w_carry || w_rs >= r_den) begin
                n_r = w_rs - r_den;
                n_q[0] = 1'b1;
            end
            n_p = w_pos;
            if (w_pos == 8'd0 || r_q[63]) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0;
        end else begin
            r_busy <= n_busy; r_done <= n_done;
        end
        r_q <= n_q; r_r <= n_r; r_p <= n_p; r_sat <= n_sat;
        if (i_go) begin
            r_num <= i_num; r_den <= i_den; r_sh <= i_sh;
        end
    end

    assign o_done = r_done;
    assign o_q    = n_sat ? '1 : r_q;
endmodule

// File: rtl/trhf_datapath.sv
// Datapath: input word, recursion registers, product, divider, output word.
// Depends on trhf_pkg and trhf_div.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trhf_datapath #(
    parameter int unsigned MAX_TERMS = trhf_pkg::MAX_TERMS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  trhf_pkg::t_cmd   i_cmd,
    output trhf_pkg::t_sts   o_sts,
    input  logic [31:0]      i_angle_alpha,
    input  logic [31:0]      i_angle_beta,
    input  logic             i_want_height,
    input  logic [22:0]      i_ih,
    input  logic [4:0]       i_tc,
    input  logic             i_out_stall,
    output logic             o_out_valid,
    output logic [31:0]      o_distance,
    output logic [31:0]      o_object_height,
    output logic [1:0]       o_error_code,
    output logic             o_saturated
);
    import trhf_pkg::*;
    localparam int IW = $clog2(MAX_TERMS + 1) + 1;

    logic [31:0] r_a, r_b, r_x;
    logic        r_w;
    logic [22:0] r_c;
    logic [IW-1:0] r_i, w_n;
    logic [63:0] r_v, r_d;
    logic [31:0] r_dist, r_h;
    logic [1:0]  r_err;
    logic        r_sat, r_ov;
    logic [63:0] w_num, w_den, w_q;
    logic [6:0]  w_sh;
    logic        w_done;
    logic [31:0] w_mop;
    logic [54:0] w_mul, r_plo;
    logic [55:0] w_phi;
    logic [32:0] w_hs;

    always_comb begin
        if (i_tc == 5'd0) w_n = IW'(1);
        else if (32'(i_tc) > MAX_TERMS) w_n = IW'(MAX_TERMS);
        else w_n = IW'(i_tc);
        case (i_cmd.div_op)
            t_DIV_Q: begin
                w_num = 64'({r_i, 1'b0} - 1'b1); w_sh = 7'd62; w_den = {32'd0, r_x};
            end
            t_DIV_V: begin
                w_num = 64'd1; w_sh = 7'd64; w_den = r_d;
            end
            t_DIV_H: begin
                w_num = {32'd0, r_dist}; w_sh = 7'd32; w_den = r_d;
            end
            default: begin
                w_num = '0; w_sh = '0; w_den = '0;
            end
        endcase
        // c * d1 in two 23x32 halves; upper half plus carry-in of the lower
        w_mop = i_cmd.mul_lo ? r_d[31:0] : r_d[63:32];
        w_mul = 55'(r_c) * 55'(w_mop);
        w_phi = 56'(w_mul) + 56'(r_plo[54:32]);
        w_hs = 33'(w_q[31:0]) + 33'(r_c);
    end

    trhf_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(i_cmd.div_go), .i_num(w_num),
        .i_sh(w_sh), .i_den(w_den), .o_done(w_done), .o_q(w_q)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_angle_alpha; r_b <= i_angle_beta; r_w <= i_want_height;
            r_c <= i_ih; r_err <= ERR_OK; r_sat <= 1'b0;
            r_dist <= '0; r_h <= '0;
        end
        if (i_cmd.init_a || i_cmd.init_b) begin
            r_x <= i_cmd.init_a ? r_a : r_b; r_i <= w_n; r_v <= '0;
        end
        if (i_cmd.take_q) r_d <= (w_q > r_v) ? w_q - r_v : 64'd1;
        if (i_cmd.take_v) begin
            r_v <= w_q; r_i <= r_i - 1'b1;
        end
        if (i_cmd.mul_lo) r_plo <= w_mul;
        if (i_cmd.do_mul) begin
            if (w_phi[55:32] != '0) begin
                r_dist <= '1; r_sat <= 1'b1;
            end else r_dist <= w_phi[31:0];
        end
        if (i_cmd.take_h) begin
            if (w_q[63:32] != '0) begin
                r_h <= '1; r_sat <= 1'b1;
            end else if (w_hs[32]) begin
                r_h <= '1; r_sat <= 1'b1;
            end else r_h <= w_hs[31:0];
        end
        if (i_cmd.set_ea) r_err <= ERR_ALPHA;
        if (i_cmd.set_eb) r_err <= ERR_BETA;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (i_cmd.out_set) r_ov <= 1'b1;
        else if (r_ov && !i_out_stall) r_ov <= 1'b0;
        if (i_cmd.out_set) begin
            o_distance <= r_dist; o_object_height <= r_h;
            o_error_code <= r_err; o_saturated <= r_sat;
        end
    end

    assign o_out_valid = r_ov;
    assign o_sts.alpha_ok  = (r_a != '0) && (r_a <= ANGLE_LIMIT);
    assign o_sts.beta_ok   = (r_b != '0) && (r_b <= ANGLE_LIMIT);
    assign o_sts.want      = r_w;
    assign o_sts.last_term = (r_i == IW'(1));
    assign o_sts.div_done  = w_done;
    assign o_sts.out_busy  = r_ov;

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_ov && i_out_stall, r_ov && $stable(o_distance))
    `ASSERT_ALWAYS(a_no_reload, i_clk, i_rst_n, !(i_cmd.out_set && r_ov && i_out_stall))
    `ASSERT_ALWAYS(a_i_range, i_clk, i_rst_n, !(i_cmd.take_q && r_i == '0))
endmodule

// File: rtl/trhf_ctrl.sv
// Sequencer for the continued fraction recursion and result assembly.
// Depends on trhf_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module trhf_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  trhf_pkg::t_sts i_sts,
    output trhf_pkg::t_cmd o_cmd
);
    import trhf_pkg::*;
    t_state r_state, n_state;
    logic   r_beta, n_beta; // recursion runs on beta

    always_comb begin
        n_state = r_state; n_beta = r_beta;
        case (r_state)
            t_IDLE:   if (i_in_valid) n_state = t_CHECK;
            t_CHECK: begin
                if (!i_sts.alpha_ok) n_state = t_FIN;
                else begin
                    n_state = t_QSTART; n_beta = 1'b0;
                end
            end
            t_QSTART: n_state = t_QWAIT;
            t_QWAIT: begin
                if (i_sts.div_done)
                    n_state = i_sts.last_term ? (r_beta ? t_HSTART : t_MUL) : t_VSTART;
            end
            t_VSTART: n_state = t_VWAIT;
            t_VWAIT:  if (i_sts.div_done) n_state = t_QSTART;
            t_MUL:    n_state = t_MUL2;
            t_MUL2: begin
                if (!i_sts.want) n_state = t_FIN;
                else if (!i_sts.beta_ok) n_state = t_FIN;
                else begin
                    n_state = t_BSTART; n_beta = 1'b1;
                end
            end
            t_BSTART: n_state = t_QSTART;
            t_HSTART: n_state = t_HWAIT;
            t_HWAIT:  if (i_sts.div_done) n_state = t_FIN;
            t_FIN:    if (!i_sts.out_busy) n_state = t_OUT;
            t_OUT:    n_state = t_IDLE;
            default:  n_state = t_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.div_op = t_DIV_Q;
        o_in_stall = (r_state != t_IDLE);
        case (r_state)
            t_IDLE:   o_cmd.load = i_in_valid;
            t_CHECK: begin
                o_cmd.set_ea = !i_sts.alpha_ok; o_cmd.init_a = i_sts.alpha_ok;
            end
            t_QSTART: o_cmd.div_go = 1'b1;
            t_QWAIT: begin
                o_cmd.take_q = i_sts.div_done;
            end
            t_VSTART: begin
                o_cmd.div_go = 1'b1; o_cmd.div_op = t_DIV_V;
            end
            t_VWAIT: begin
                o_cmd.div_op = t_DIV_V; o_cmd.take_v = i_sts.div_done;
            end
            t_MUL:    o_cmd.mul_lo = 1'b1;
            t_MUL2: begin
                o_cmd.do_mul = 1'b1;
                o_cmd.set_eb = i_sts.want && !i_sts.beta_ok;
            end
            t_BSTART: o_cmd.init_b = 1'b1;
            t_HSTART: begin
                o_cmd.div_go = 1'b1; o_cmd.div_op = t_DIV_H;
            end
            t_HWAIT: begin
                o_cmd.div_op = t_DIV_H; o_cmd.take_h = i_sts.div_done;
            end
            t_OUT:    o_cmd.out_set = 1'b1;
            default:  o_cmd = o_cmd;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_IDLE; r_beta <= 1'b0;
        end else begin
            r_state <= n_state; r_beta <= n_beta;
        end
    end

    `ASSERT_NEXT(a_load_leaves, i_clk, i_rst_n, o_cmd.load, r_state == t_CHECK)
    `ASSERT_ALWAYS(a_one_err, i_clk, i_rst_n, !(o_cmd.set_ea && o_cmd.set_eb))
endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for tangent_range_height_finder: APB setup, angle words in, results out.
// Depends on trhf_pkg and the block's RTL; carries its own fixed-point tangent predictor.
`timescale 1ns / 1ps
module tb_top;
    import trhf_pkg::*;

    localparam int unsigned TERMS_CAP = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_angle_alpha;
    logic [31:0] i_angle_beta;
    logic        i_want_height;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_distance;
    logic [31:0] o_object_height;
    logic [1:0]  o_error_code;
    logic        o_saturated;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tangent_range_height_finder dut (.*);

    typedef struct {
        logic [31:0] distance;
        logic [31:0] height;
        logic [1:0]  err;
        logic        sat;
    } t_range_res;

    class range_scoreboard;
        t_range_res  pending_q[$];
        logic [22:0] inst_h;
        logic [4:0]  terms;
        int          errors;

        function new();
            inst_h = IH_RESET;
            terms  = TC_RESET;
            errors = 0;
        endfunction

        // floor(num * 2^sh / den), saturating at 64 bits
        function logic [63:0] shift_div(logic [63:0] num, int sh, logic [63:0] den);
            logic [127:0] w;
            if (den == 0) return '1;
            w = ({64'd0, num} << sh) / {64'd0, den};
            if (w[127:64] != 0) return '1;
            return w[63:0];
        endfunction

        // outermost continued-fraction denominator, deepest term first
        function logic [63:0] outer_denom(logic [31:0] x, int n);
            logic [63:0] v, q;
            v = 0;
            for (int i = n; i >= 2; i--) begin
                q = shift_div(64'(2 * i - 1), 62, {32'd0, x});
                v = shift_div(64'd1, 64, (q > v) ? q - v : 64'd1);
            end
            q = shift_div(64'd1, 62, {32'd0, x});
            return (q > v) ? q - v : 64'd1;
        endfunction

        function bit angle_ok(logic [31:0] a);
            return a != 0 && a <= ANGLE_LIMIT;
        endfunction

        function void note(logic [31:0] alpha, logic [31:0] beta, logic want);
            t_range_res   r;
            int           n;
            logic [127:0] prod;
            logic [63:0]  t, hsum;
            r = '{0, 0, ERR_OK, 0};
            n = (terms == 0) ? 1 : (terms > TERMS_CAP) ? TERMS_CAP : terms;
            if (!angle_ok(alpha)) begin
                r.err = ERR_ALPHA;
            end else begin
                prod = {105'd0, inst_h} * {64'd0, outer_denom(alpha, n)};
                if (prod[127:64] != 0) begin
                    r.distance = '1;
                    r.sat      = 1;
                end else begin
                    r.distance = prod[63:32];
                end
                if (want) begin
                    if (!angle_ok(beta)) begin
                        r.err = ERR_BETA;
                    end else begin
                        t = shift_div({32'd0, r.distance}, 32, outer_denom(beta, n));
                        if (t > 64'hFFFF_FFFF) begin
                            t = 64'hFFFF_FFFF;
                            r.sat = 1;
                        end
                        hsum = t + inst_h;
                        if (hsum > 64'hFFFF_FFFF) begin
                            hsum = 64'hFFFF_FFFF;
                            r.sat = 1;
                        end
                        r.height = hsum[31:0];
                    end
                end
            end
            pending_q.push_back(r);
        endfunction

        function void check(logic [31:0] d, logic [31:0] h, logic [1:0] e, logic s);
            t_range_res x;
            if (pending_q.size() == 0) begin
                $display("%0t: unexpected result word distance=%h", $time, d);
                errors++;
                return;
            end
            x = pending_q.pop_front();
            if (d !== x.distance) begin
                $display("%0t: distance exp %h got %h", $time, x.distance, d);
                errors++;
            end
            if (h !== x.height) begin
                $display("%0t: object_height exp %h got %h", $time, x.height, h);
                errors++;
            end
            if (e !== x.err) begin
                $display("%0t: error_code exp %0d got %0d", $time, x.err, e);
                errors++;
            end
            if (s !== x.sat) begin
                $display("%0t: saturated exp %0d got %0d", $time, x.sat, s);
                errors++;
            end
        endfunction
    endclass

    range_scoreboard sb = new();
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_off_len   = 0;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall, or one long hold-off when asked
    initial begin
        i_out_stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                i_out_stall <= 1;
                hold_off_len--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check(o_distance, o_object_height, o_error_code, o_saturated);

    task automatic apb_write(logic [0:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1;
        do @(posedge i_clk); while (!pready);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        if (idx == REG_IH) sb.inst_h = val[22:0];
        else sb.terms = val[4:0];
    endtask

    task automatic send_word(logic [31:0] a, logic [31:0] b, logic w);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid    <= 1;
        i_angle_alpha <= a;
        i_angle_beta  <= b;
        i_want_height <= w;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        sb.note(a, b, w);
    endtask

    task automatic drain();
        i_in_valid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(9))
            0:       return $urandom();
            1:       return $urandom_range(1, 4096);
            2:       return $urandom_range(ANGLE_LIMIT + 1, 32'hFFFF_FFFF);
            default: return $urandom_range(1, ANGLE_LIMIT);
        endcase
    endfunction

    task automatic random_words(int count);
        repeat (count) send_word(rand_angle(), rand_angle(), $urandom_range(1));
    endtask

    initial begin
        i_rst_n       = 0;
        i_in_valid    = 0;
        i_angle_alpha = 0;
        i_angle_beta  = 0;
        i_want_height = 0;
        psel          = 0;
        penable       = 0;
        pwrite        = 0;
        paddr         = 0;
        pwdata        = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: range edges, beta handling, saturation, reset registers
        send_word(0, 1, 1);
        send_word(1, 1, 1);
        send_word(ANGLE_LIMIT, ANGLE_LIMIT, 1);
        send_word(ANGLE_LIMIT + 1, 1, 1);
        send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
        send_word(32'h4000_0000, 0, 1);
        send_word(32'h4000_0000, ANGLE_LIMIT + 1, 1);
        send_word(32'h4000_0000, 32'hFFFF_FFFF, 1);
        send_word(32'h2000_0000, 32'h5000_0000, 0);
        send_word(32'h2000_0000, 32'h5000_0000, 1);
        send_word(ANGLE_LIMIT, 1, 1);
        send_word(1, ANGLE_LIMIT, 1);
        drain();

        apb_write(REG_IH, 1);
        apb_write(REG_TC, 0);
        send_word(1, 1, 1);
        send_word(ANGLE_LIMIT, ANGLE_LIMIT, 1);
        random_words(60);
        drain();

        send_idle_pct = 71;
        apb_write(REG_IH, 6553600);
        apb_write(REG_TC, 16);
        send_word(1, ANGLE_LIMIT, 1);
        send_word(ANGLE_LIMIT, 1, 1);
        random_words(8);
        drain();

        send_idle_pct = 0;
        stall_pct     = 71;
        apb_write(REG_IH, 23'h7FFFFF);
        apb_write(REG_TC, 31);
        send_word(1, 1, 1);
        random_words(6);
        drain();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 37;
        stall_pct     = 37;
        apb_write(REG_IH, $urandom_range(1, 6553600));
        apb_write(REG_TC, 1);
        hold_off_len = 4000;
        random_words(300);
        drain();

        send_idle_pct = 71;
        stall_pct     = 0;
        apb_write(REG_IH, $urandom_range(1, 23'h7FFFFF));
        apb_write(REG_TC, 2);
        random_words(300);
        drain();

        send_idle_pct = 0;
        stall_pct     = 71;
        apb_write(REG_IH, $urandom_range(1, 6553600));
        apb_write(REG_TC, 3);
        random_words(250);
        drain();

        stall_pct = 0;
        apb_write(REG_IH, $urandom_range(1, 6553600));
        apb_write(REG_TC, $urandom_range(1, 5));
        random_words(170);
        drain();
        repeat (600) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
